>>> sv/rhcc_pkg.sv
package rhcc_pkg;

    // field widths
    localparam int CH_W   = 8;
    localparam int HUE_W  = 9;
    localparam int NUM_W  = 17;
    localparam int DIV_STEPS = 9;

    // hexcone offsets in degrees
    localparam logic [7:0] GREEN_BASE = 8'd120;
    localparam logic [7:0] BLUE_BASE  = 8'd240;
    localparam logic [HUE_W-1:0] HUE_FULL = 9'd360;
    localparam logic signed [NUM_W+1:0] HUE_SECTOR = 19'sd60;

    // classification windows
    localparam logic [HUE_W-1:0] RED_HUE_HI  = 9'd245;
    localparam logic [HUE_W-1:0] RED_HUE_LO  = 9'd36;
    localparam logic [HUE_W-1:0] BLUE_HUE_LO = 9'd198;
    localparam logic [HUE_W-1:0] BLUE_HUE_HI = 9'd234;
    localparam logic [HUE_W-1:0] YEL_HUE_LO  = 9'd36;
    localparam logic [HUE_W-1:0] YEL_HUE_HI  = 9'd72;
    localparam logic [CH_W-1:0]  SAT_MIN      = 8'd128;
    localparam logic [CH_W-1:0]  BLUE_SAT_MAX = 8'd242;
    localparam logic [CH_W-1:0]  YEL_SAT_MIN  = 8'd141;
    localparam logic [CH_W-1:0]  YEL_SAT_MAX  = 8'd204;
    localparam logic [CH_W-1:0]  BRIGHT_MIN   = 8'd128;

    // which channel holds the maximum
    typedef enum logic [2:0] {
        SEL_RED   = 3'b001,
        SEL_GREEN = 3'b010,
        SEL_BLUE  = 3'b100
    } t_sel;

    // word handed from cell to cell along the divider chain
    typedef struct packed {
        logic [NUM_W-1:0] h_rem;
        logic [NUM_W-1:0] h_den;
        logic [HUE_W-1:0] h_quo;
        logic [NUM_W-1:0] s_rem;
        logic [NUM_W-1:0] s_den;
        logic [HUE_W-1:0] s_quo;
        logic             h_neg;
        logic             h_zero;
        logic             s_zero;
        logic [CH_W-1:0]  bright;
    } t_div_word;

    // finished pixel
    typedef struct packed {
        logic             is_yellow;
        logic             is_blue;
        logic             is_red;
        logic [CH_W-1:0]  bright;
        logic [CH_W-1:0]  sat;
        logic [HUE_W-1:0] hue;
    } t_result;

endpackage

>>> sv/rhcc_front.sv
module rhcc_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [rhcc_pkg::CH_W-1:0]   i_red,
    input  logic [rhcc_pkg::CH_W-1:0]   i_green,
    input  logic [rhcc_pkg::CH_W-1:0]   i_blue,
    output logic                        o_valid,
    input  logic                        i_ready,
    output rhcc_pkg::t_div_word         o_word
);

    // stage a: max, min, chroma and the signed channel difference
    logic                              r_a_valid;
    rhcc_pkg::t_sel                    r_a_sel;
    logic signed [rhcc_pkg::CH_W:0]    r_a_d;
    logic [rhcc_pkg::CH_W-1:0]         r_a_c;
    logic [rhcc_pkg::CH_W-1:0]         r_a_mx;
    logic                              r_a_neg;

    rhcc_pkg::t_sel                    n_a_sel;
    logic signed [rhcc_pkg::CH_W:0]    n_a_d;
    logic [rhcc_pkg::CH_W-1:0]         n_a_mx;
    logic [rhcc_pkg::CH_W-1:0]         n_a_mn;
    logic                              n_a_neg;

    // stage b: numerators and shifted divisors
    logic                              r_b_valid;
    rhcc_pkg::t_div_word               r_b_word;
    rhcc_pkg::t_div_word               n_b_word;
    logic [15:0]                       base_c;
    logic signed [rhcc_pkg::NUM_W+1:0] h_scaled;
    logic signed [rhcc_pkg::NUM_W+1:0] h_sum;

    logic a_ready;
    logic b_ready;

    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;
    assign o_valid = r_b_valid;
    assign o_word  = r_b_word;

    // channel compare, red wins ties, then green
    always_comb begin
        n_a_mn  = i_red;
        n_a_neg = 1'b0;
        if (i_green < n_a_mn) begin
            n_a_mn = i_green;
        end
        if (i_blue < n_a_mn) begin
            n_a_mn = i_blue;
        end
        if (i_red >= i_green && i_red >= i_blue) begin
            n_a_sel = rhcc_pkg::SEL_RED;
            n_a_mx  = i_red;
            n_a_neg = i_green < i_blue;
            n_a_d   = n_a_neg ? $signed({1'b0, i_blue - i_green})
                              : $signed({1'b0, i_green - i_blue});
        end else if (i_green >= i_blue) begin
            n_a_sel = rhcc_pkg::SEL_GREEN;
            n_a_mx  = i_green;
            n_a_d   = $signed({1'b0, i_blue}) - $signed({1'b0, i_red});
        end else begin
            n_a_sel = rhcc_pkg::SEL_BLUE;
            n_a_mx  = i_blue;
            n_a_d   = $signed({1'b0, i_red}) - $signed({1'b0, i_green});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= i_valid;
        end
        if (a_ready && i_valid) begin
            r_a_sel <= n_a_sel;
            r_a_d   <= n_a_d;
            r_a_c   <= n_a_mx - n_a_mn;
            r_a_mx  <= n_a_mx;
            r_a_neg <= n_a_neg;
        end
    end

    // sector offset times chroma
    always_comb begin
        case (r_a_sel)
            rhcc_pkg::SEL_RED:   base_c = 16'd0;
            rhcc_pkg::SEL_GREEN: base_c = {8'b0, r_a_c} * {8'b0, rhcc_pkg::GREEN_BASE};
            rhcc_pkg::SEL_BLUE:  base_c = {8'b0, r_a_c} * {8'b0, rhcc_pkg::BLUE_BASE};
            default:             base_c = 16'd0;
        endcase
    end

    // hue numerator is always non-negative and below 2^17
    assign h_scaled = (rhcc_pkg::NUM_W+2)'(r_a_d);
    assign h_sum    = (rhcc_pkg::NUM_W+2)'(h_scaled * rhcc_pkg::HUE_SECTOR)
                    + $signed({3'b000, base_c});

    always_comb begin
        n_b_word        = '0;
        n_b_word.h_rem  = h_sum[rhcc_pkg::NUM_W-1:0];
        n_b_word.h_den  = {1'b0, r_a_c, 8'b0};
        n_b_word.s_rem  = {1'b0, r_a_c, 8'b0} - {9'b0, r_a_c};
        n_b_word.s_den  = {1'b0, r_a_mx, 8'b0};
        n_b_word.h_neg  = r_a_neg;
        n_b_word.h_zero = (r_a_c == '0);
        n_b_word.s_zero = (r_a_mx == '0);
        n_b_word.bright = r_a_mx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
        if (b_ready && r_a_valid) begin
            r_b_word <= n_b_word;
        end
    end

endmodule

>>> sv/rhcc_div_cell.sv
module rhcc_div_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  rhcc_pkg::t_div_word i_word,
    output logic                o_valid,
    input  logic                i_ready,
    output rhcc_pkg::t_div_word o_word
);

    logic                r_valid;
    rhcc_pkg::t_div_word r_word;
    rhcc_pkg::t_div_word n_word;
    logic                h_fit;
    logic                s_fit;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    // one restoring step for hue and saturation, divisor halves for the next cell
    assign h_fit = i_word.h_rem >= i_word.h_den;
    assign s_fit = i_word.s_rem >= i_word.s_den;

    always_comb begin
        n_word       = i_word;
        n_word.h_rem = h_fit ? i_word.h_rem - i_word.h_den : i_word.h_rem;
        n_word.s_rem = s_fit ? i_word.s_rem - i_word.s_den : i_word.s_rem;
        n_word.h_quo = {i_word.h_quo[rhcc_pkg::HUE_W-2:0], h_fit};
        n_word.s_quo = {i_word.s_quo[rhcc_pkg::HUE_W-2:0], s_fit};
        n_word.h_den = {1'b0, i_word.h_den[rhcc_pkg::NUM_W-1:1]};
        n_word.s_den = {1'b0, i_word.s_den[rhcc_pkg::NUM_W-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

endmodule

>>> sv/rhcc_back.sv
module rhcc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  rhcc_pkg::t_div_word i_word,
    output logic                o_valid,
    input  logic                i_ready,
    output rhcc_pkg::t_result   o_result
);

    logic                            r_valid;
    rhcc_pkg::t_result               r_result;
    rhcc_pkg::t_result               n_result;
    logic [rhcc_pkg::HUE_W-1:0]      hue;
    logic [rhcc_pkg::CH_W-1:0]       sat;
    logic                            bright_ok;

    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // wrap negative red hue, zero the gray and black cases
    always_comb begin
        if (i_word.h_zero) begin
            hue = '0;
        end else if (i_word.h_neg && i_word.h_quo != '0) begin
            hue = rhcc_pkg::HUE_FULL - i_word.h_quo;
        end else begin
            hue = i_word.h_quo;
        end
        sat       = i_word.s_zero ? '0 : i_word.s_quo[rhcc_pkg::CH_W-1:0];
        bright_ok = i_word.bright >= rhcc_pkg::BRIGHT_MIN;
    end

    // colour windows
    always_comb begin
        n_result.hue       = hue;
        n_result.sat       = sat;
        n_result.bright    = i_word.bright;
        n_result.is_red    = (hue >= rhcc_pkg::RED_HUE_HI || hue <= rhcc_pkg::RED_HUE_LO)
                           && sat >= rhcc_pkg::SAT_MIN && bright_ok;
        n_result.is_blue   = hue >= rhcc_pkg::BLUE_HUE_LO && hue <= rhcc_pkg::BLUE_HUE_HI
                           && sat >= rhcc_pkg::SAT_MIN && sat <= rhcc_pkg::BLUE_SAT_MAX
                           && bright_ok;
        n_result.is_yellow = hue >= rhcc_pkg::YEL_HUE_LO && hue <= rhcc_pkg::YEL_HUE_HI
                           && sat >= rhcc_pkg::YEL_SAT_MIN && sat <= rhcc_pkg::YEL_SAT_MAX
                           && bright_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_result <= n_result;
        end
    end

endmodule

>>> sv/rgb_hsv_color_classifier.sv
// RGB to HSV colour classifier.
// Slave stream: one 8-bit RGB pixel per transfer on i_s_axis_tdata.
// Master stream: hue in whole degrees, saturation and value on o_m_axis_tdata,
// with the red, blue and yellow window flags on o_m_axis_tuser.
// Every pixel gives exactly one result, in order.
// An accepted transfer reaches o_m_axis_tvalid through two
// front stages (max/min/chroma, then numerators), a chain of nine divider
// cells that each resolve one quotient bit of hue and saturation together,
// and one output register that applies the hue wrap and the colour windows.
// Throughput is one pixel per clock while i_m_axis_tready stays high; the
// nine-cell divider chain sets the latency, and every stage holds its own valid bit.
// When the receiver stalls, the result holds in the output register and the
// stages behind it keep filling until each holds a pixel; only then does
// o_s_axis_tready fall.
// A synchronous low on i_rst_n empties every stage; no result is pending
// after reset and the block is ready in the next cycle.
module rgb_hsv_color_classifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // hue[8:0], saturation[16:9], brightness[24:17], zero
    output logic [2:0]  o_m_axis_tuser   // is_red[0], is_blue[1], is_yellow[2]
);

    localparam int N = rhcc_pkg::DIV_STEPS;

    logic                valid [0:N];
    logic                ready [0:N];
    rhcc_pkg::t_div_word word  [0:N];
    rhcc_pkg::t_result   result;

    // max, min, chroma and numerators
    rhcc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_red   (i_s_axis_tdata[7:0]),
        .i_green (i_s_axis_tdata[15:8]),
        .i_blue  (i_s_axis_tdata[23:16]),
        .o_valid (valid[0]),
        .i_ready (ready[0]),
        .o_word  (word[0])
    );

    // divider chain, most significant quotient bit first
    for (genvar k = 0; k < N; k++) begin : g_cell
        rhcc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (valid[k]),
            .o_ready (ready[k]),
            .i_word  (word[k]),
            .o_valid (valid[k+1]),
            .i_ready (ready[k+1]),
            .o_word  (word[k+1])
        );
    end

    // hue wrap, zero cases, colour windows and output register
    rhcc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (valid[N]),
        .o_ready  (ready[N]),
        .i_word   (word[N]),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (result)
    );

    // output packing
    assign o_m_axis_tdata = {7'b0, result.bright, result.sat, result.hue};
    assign o_m_axis_tuser = {result.is_yellow, result.is_blue, result.is_red};

endmodule

>>> sv/rhcc_checker.sv
module rhcc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic [2:0]  o_m_axis_tuser
);

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // hue stays below a full turn
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[8:0] <= 9'd359)
        else $error("hue out of range");

    // red flag needs enough saturation and brightness
    a_red_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |->
            o_m_axis_tdata[16:9] >= rhcc_pkg::SAT_MIN
            && o_m_axis_tdata[24:17] >= rhcc_pkg::BRIGHT_MIN)
        else $error("red flag outside its window");

    // blue and yellow hue windows never overlap
    a_blue_yellow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tuser[1] && o_m_axis_tuser[2]))
        else $error("blue and yellow both flagged");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed during stall");

endmodule

bind rgb_hsv_color_classifier rhcc_checker u_rhcc_checker (.*);
